### src/point_in_triangle_mesh_test_unit_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef POINT_IN_TRIANGLE_MESH_TEST_UNIT_DEFINES_SVH
`define POINT_IN_TRIANGLE_MESH_TEST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PITM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pitm assertion failed");
`define PITM_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("pitm assertion failed");
`else
`define PITM_ASSERT(lbl, prop)
`define PITM_ASSERT_NEVER(lbl, expr)
`endif

`endif

### src/pitm_pkg.sv
`timescale 1ns / 1ps

package pitm_pkg;

  localparam int unsigned VERTEX_DEPTH_DEF = 64;

  localparam int CoordW = 16;
  localparam int TranW  = 17;
  localparam int EdgeW  = 18;
  localparam int ProdW  = 36;
  localparam int CrossW = 37;
  localparam int SumW   = 38;
  localparam int CountW = 7;
  localparam int IndexW = 6;
  localparam int CfgIdxW = 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET_X     = 2'd0,
    CFG_OFFSET_Y     = 2'd1,
    CFG_VERTEX_COUNT = 2'd2
  } cfg_idx_e;

  typedef logic signed [TranW-1:0]  tcoord_t;
  typedef logic signed [EdgeW-1:0]  ecoord_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [CrossW-1:0] cross_t;
  typedef logic signed [SumW-1:0]   sum_t;

  typedef struct packed {
    tcoord_t x;
    tcoord_t y;
  } vtx_t;

  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
    vtx_t p;
  } tri_t;

  typedef struct packed {
    logic active;
    logic hit_valid;
    logic hit;
  } eval_st_t;

  function automatic tcoord_t ext_t(input logic [CoordW-1:0] v);
    return {v[CoordW-1], v};
  endfunction

  function automatic ecoord_t ext_e(input tcoord_t v);
    return {v[TranW-1], v};
  endfunction

  function automatic cross_t ext_c(input prod_t v);
    return {v[ProdW-1], v};
  endfunction

  function automatic sum_t ext_s(input cross_t v);
    return {v[CrossW-1], v};
  endfunction

endpackage

### src/point_in_triangle_mesh_test_unit.sv
// Point-in-triangle-mesh test.
// Items enter on start/busy: an item is taken at a clock edge with start high
// and busy low. operation_i selects a vertex write (vertex_index_i, coord_x_i,
// coord_y_i go into the vertex memory) or a point query (coord_x_i, coord_y_i).
// A write gives no result; busy stays low.
// A query walks the vertex memory one entry per cycle through its single read
// port, three reads per triangle, and feeds each triangle to a four-stage
// arithmetic pipeline. valid_o then pulses for one cycle with inside_res_o;
// the memory read port sets the pace. busy is high until the result cycle,
// in which the next item may already be taken.
// Results cannot be held off: each is shown for exactly one cycle.
// Registers are written on cfg_valid_i/cfg_ready_o (always ready); the user
// must write them only while idle, which the block itself does not enforce.
// Index 0 offset x, 1 offset y, 2 vertex count; other indexes are ignored.
// Reset clears the offsets, the count and all control state. The vertex
// memory is not cleared; entries must be written before a query uses them.
`timescale 1ns / 1ps
`include "point_in_triangle_mesh_test_unit_defines.svh"

module point_in_triangle_mesh_test_unit #(
  parameter int unsigned VERTEX_DEPTH = pitm_pkg::VERTEX_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               operation_i,
  input  logic [pitm_pkg::IndexW-1:0]        vertex_index_i,
  input  logic signed [pitm_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [pitm_pkg::CoordW-1:0] coord_y_i,
  output logic                               valid_o,
  output logic                               inside_res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pitm_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [pitm_pkg::CoordW-1:0]        cfg_data_i
);
  import pitm_pkg::*;

  localparam int AW = $clog2(VERTEX_DEPTH);
  localparam int CW = $clog2(VERTEX_DEPTH + 4);
  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic signed [CoordW-1:0] offset_x_q, offset_y_q;
  logic [CountW-1:0] vertex_count_q;
  logic [CW-1:0] base_q, base_d, cnt_q, cnt_d, cnt_sat;
  logic [1:0] phase_q, phase_d, rd_phase_q;
  logic signed [CoordW-1:0] px_q, py_q;
  logic hit_q, hit_d;
  logic valid_q, valid_d, inside_q, inside_d;
  logic accept, idx_ok, ram_we, tri_ok;
  logic rd_en, rd_valid_q, tri_valid_q;
  logic [AW-1:0] rd_addr;
  logic [2*CoordW-1:0] rdata;
  vtx_t vtx_rd, vtx_a_q, vtx_b_q, vtx_c_q;
  tri_t tri_s;
  eval_st_t eval_st;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign idx_ok      = 32'(vertex_index_i) < 32'(VERTEX_DEPTH);
  assign ram_we      = accept && (operation_i == OP_WRITE) && idx_ok;
  assign cnt_sat     = (32'(vertex_count_q) > 32'(VERTEX_DEPTH)) ?
                       CW'(VERTEX_DEPTH) : CW'(vertex_count_q);
  assign tri_ok      = (base_q + CW'(3)) <= cnt_q;

  pitm_ram #(
    .WIDTH(2 * CoordW),
    .DEPTH(VERTEX_DEPTH)
  ) u_vertex_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(vertex_index_i)),
    .wdata_i({coord_x_i, coord_y_i}),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q     <= '0;
      offset_y_q     <= '0;
      vertex_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_OFFSET_X:     offset_x_q     <= cfg_data_i;
        CFG_OFFSET_Y:     offset_y_q     <= cfg_data_i;
        CFG_VERTEX_COUNT: vertex_count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    base_d   = base_q;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    hit_d    = hit_q || (eval_st.hit_valid && eval_st.hit);
    valid_d  = 1'b0;
    inside_d = inside_q;
    rd_en    = 1'b0;
    rd_addr  = AW'(base_q + CW'(phase_q));
    case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == OP_QUERY)) begin
          state_d = ST_RUN;
          base_d  = '0;
          phase_d = PH_A;
          cnt_d   = cnt_sat;
          hit_d   = 1'b0;
        end
      end
      ST_RUN: begin
        if (tri_ok) begin
          rd_en = 1'b1;
          if (phase_q == PH_C) begin
            phase_d = PH_A;
            base_d  = base_q + CW'(3);
          end else begin
            phase_d = phase_q + 2'd1;
          end
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid_q && !tri_valid_q && !eval_st.active) begin
          state_d  = ST_IDLE;
          valid_d  = 1'b1;
          inside_d = hit_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      phase_q     <= PH_A;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      valid_q     <= 1'b0;
      inside_q    <= 1'b0;
      rd_valid_q  <= 1'b0;
      rd_phase_q  <= PH_A;
      tri_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      valid_q     <= valid_d;
      inside_q    <= inside_d;
      rd_valid_q  <= rd_en;
      rd_phase_q  <= phase_q;
      tri_valid_q <= rd_valid_q && (rd_phase_q == PH_C);
    end
  end

  assign vtx_rd.x = ext_t(rdata[2*CoordW-1:CoordW]) + ext_t(offset_x_q);
  assign vtx_rd.y = ext_t(rdata[CoordW-1:0]) + ext_t(offset_y_q);

  always_ff @(posedge clk_i) begin
    if (accept && (operation_i == OP_QUERY)) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
    if (rd_valid_q) begin
      case (rd_phase_q)
        PH_A:    vtx_a_q <= vtx_rd;
        PH_B:    vtx_b_q <= vtx_rd;
        PH_C:    vtx_c_q <= vtx_rd;
        default: ;
      endcase
    end
  end

  always_comb begin
    tri_s.a   = vtx_a_q;
    tri_s.b   = vtx_b_q;
    tri_s.c   = vtx_c_q;
    tri_s.p.x = ext_t(px_q);
    tri_s.p.y = ext_t(py_q);
  end

  pitm_tri_eval u_tri_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tri_valid_i(tri_valid_q),
    .tri_i      (tri_s),
    .status_o   (eval_st)
  );

  assign valid_o      = valid_q;
  assign inside_res_o = inside_q;

  `PITM_ASSERT(a_idle_quiet, state_q == ST_IDLE |-> !(rd_valid_q || tri_valid_q || eval_st.active))
  `PITM_ASSERT_NEVER(a_rd_past_count, rd_en && ((base_q + CW'(phase_q)) >= cnt_q))
  `PITM_ASSERT(a_result_after_drain, valid_o |-> $past(state_q == ST_DRAIN))
  `PITM_ASSERT(a_result_single, valid_o |=> !valid_o)

endmodule

### src/pitm_ram.sv
`timescale 1ns / 1ps

module pitm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/pitm_tri_eval.sv
`timescale 1ns / 1ps

module pitm_tri_eval (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tri_valid_i,
  input  pitm_pkg::tri_t     tri_i,
  output pitm_pkg::eval_st_t status_o
);
  import pitm_pkg::*;

  ecoord_t e0x_q, e0y_q, e1x_q, e1y_q, e2x_q, e2y_q;
  prod_t   pd0_q, pd1_q, pu0_q, pu1_q, pv0_q, pv1_q;
  cross_t  d_q, nu_q, nv_q;
  sum_t    s_d, dd_d;
  logic    v1_q, v2_q, v3_q, v4_q;
  logic    hit_q, hit_d;
  logic    d_pos, d_neg, nu_pos, nv_pos, nu_neg, nv_neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= tri_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // edges, cross products, differences, sign-aware compare
  always_ff @(posedge clk_i) begin
    if (tri_valid_i) begin
      e0x_q <= ext_e(tri_i.c.x) - ext_e(tri_i.a.x);
      e0y_q <= ext_e(tri_i.c.y) - ext_e(tri_i.a.y);
      e1x_q <= ext_e(tri_i.b.x) - ext_e(tri_i.a.x);
      e1y_q <= ext_e(tri_i.b.y) - ext_e(tri_i.a.y);
      e2x_q <= ext_e(tri_i.p.x) - ext_e(tri_i.a.x);
      e2y_q <= ext_e(tri_i.p.y) - ext_e(tri_i.a.y);
    end
    if (v1_q) begin
      pd0_q <= e0x_q * e1y_q;
      pd1_q <= e0y_q * e1x_q;
      pu0_q <= e2x_q * e1y_q;
      pu1_q <= e2y_q * e1x_q;
      pv0_q <= e0x_q * e2y_q;
      pv1_q <= e0y_q * e2x_q;
    end
    if (v2_q) begin
      d_q  <= ext_c(pd0_q) - ext_c(pd1_q);
      nu_q <= ext_c(pu0_q) - ext_c(pu1_q);
      nv_q <= ext_c(pv0_q) - ext_c(pv1_q);
    end
    if (v3_q) begin
      hit_q <= hit_d;
    end
  end

  // negative determinant: flip the sense of every compare instead of negating
  always_comb begin
    s_d    = ext_s(nu_q) + ext_s(nv_q);
    dd_d   = ext_s(d_q);
    d_neg  = d_q[CrossW-1];
    d_pos  = !d_q[CrossW-1] && (d_q != '0);
    nu_pos = !nu_q[CrossW-1];
    nv_pos = !nv_q[CrossW-1];
    nu_neg = nu_q[CrossW-1] || (nu_q == '0);
    nv_neg = nv_q[CrossW-1] || (nv_q == '0);
    hit_d  = (d_pos && nu_pos && nv_pos && (s_d < dd_d)) ||
             (d_neg && nu_neg && nv_neg && (s_d > dd_d));
  end

  assign status_o.active    = v1_q || v2_q || v3_q || v4_q;
  assign status_o.hit_valid = v4_q;
  assign status_o.hit       = hit_q;

endmodule
